@@ hdl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Entry layout, operation and status codes, order modes and the relation
// test that every cell applies to its stored priority.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // Number of cells in the chain, and count width able to hold CAPACITY itself
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned DATA_W   = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_TOP  = 2'd1,
    FUNC_POP  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Relation of stored priority to incoming priority
  typedef enum logic [1:0] {
    ORD_LT = 2'd0,
    ORD_LE = 2'd1,
    ORD_GT = 2'd2,
    ORD_GE = 2'd3
  } order_e;

  localparam order_e ORDER_RESET = ORD_LE;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic   push;
    logic   pop;
    order_e mode;
  } cell_ctrl_t;

  // True when relation(stored, fresh) holds under the given mode
  function automatic logic relation_holds(order_e mode,
                                          logic signed [DATA_W-1:0] stored,
                                          logic signed [DATA_W-1:0] fresh);
    logic res;
    case (mode)
      ORD_LT:  res = (stored <  fresh);
      ORD_LE:  res = (stored <= fresh);
      ORD_GT:  res = (stored >  fresh);
      ORD_GE:  res = (stored >= fresh);
      default: res = (stored >= fresh);
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hdl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry. On a push it keeps its entry, takes the new one, or takes
// its left neighbor's entry; on a pop it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic               clk_i,
  input  wire spq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic               occupied_i,
  input  wire logic               pass_i,
  input  wire spq_pkg::entry_t    new_i,
  input  wire spq_pkg::entry_t    left_i,
  input  wire spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t         entry_o,
  output logic                    pass_o
);

  spq_pkg::entry_t entry_q, entry_d;
  logic            hold;

  // New item goes past this slot only if the slot is live and the relation holds
  assign hold   = occupied_i & spq_pkg::relation_holds(ctrl_i.mode, entry_q.prio, new_i.prio);
  assign pass_o = pass_i & hold;

  // Slot update: insertion point takes the new entry, slots after it shift right
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      if (!pass_i) begin
        entry_d = left_i;
      end else if (!hold) begin
        entry_d = new_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

@@ hdl/sorted_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded sorted priority queue
// Chain of CAPACITY cells kept in priority order, head in cell 0.
// ----------------------------------------------------------------------------
// For each item (push, top or pop), every cell compares its
// stored priority with the incoming one in parallel, a pass signal ripples
// down the chain to mark the first slot where the order relation fails, and
// all cells update at once (insert and shift right on push, shift left on
// pop). The result sits in an output register, so a new item is taken every
// cycle unless that register holds a result that is stalled. Pushes into a
// full queue are dropped with a full status; top or pop on an empty queue
// return an empty status with zero data. order_mode may be written only
// while no item is in flight.
`default_nettype none

module sorted_priority_queue_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_data_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic signed [31:0] elem_value_i,
  input  wire logic signed [31:0] priority_req_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] out_value_o,
  output logic signed [31:0] out_priority_o,
  output logic [1:0]       status_o,
  output logic             now_empty_o
);

  localparam int unsigned CAP   = spq_pkg::CAPACITY;
  localparam int unsigned CNT_W = spq_pkg::CNT_W;

  spq_pkg::order_e     mode_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                out_valid_q;
  spq_pkg::entry_t     res_q, res_d;
  spq_pkg::status_e    status_q, status_d;
  logic                empty_q, empty_d;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     new_entry;
  spq_pkg::entry_t     cell_entry [CAP];
  logic                pass_w     [CAP+1];
  spq_pkg::func_e      func;
  logic                fire, full, empty;

  // Order mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= spq_pkg::ORDER_RESET;
    end else if (cfg_we_i) begin
      mode_q <= spq_pkg::order_e'(cfg_data_i);
    end
  end

  assign func       = spq_pkg::func_e'(func_i);
  assign in_stall_o = out_valid_q & out_stall_i;
  assign fire       = in_valid_i & ~in_stall_o;
  assign full       = (count_q == CNT_W'(CAP));
  assign empty      = (count_q == '0);

  assign new_entry.value = elem_value_i;
  assign new_entry.prio  = priority_req_i;

  // Broadcast control
  always_comb begin
    ctrl.mode = mode_q;
    ctrl.push = fire & (func == spq_pkg::FUNC_PUSH) & ~full;
    ctrl.pop  = fire & (func == spq_pkg::FUNC_POP) & ~empty;
  end

  // Cell chain
  assign pass_w[0] = 1'b1;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    spq_pkg::entry_t left_e, right_e;

    if (i == 0) begin : g_head
      assign left_e = new_entry;
    end else begin : g_body
      assign left_e = cell_entry[i-1];
    end

    if (i == CAP - 1) begin : g_tail
      assign right_e = '0;
      spq_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occupied_i (CNT_W'(i) < count_q),
        .pass_i     (pass_w[i]),
        .new_i      (new_entry),
        .left_i     (left_e),
        .right_i    (right_e),
        .entry_o    (cell_entry[i]),
        .pass_o     (pass_w[i+1])
      );
    end else begin : g_link
      assign right_e = cell_entry[i+1];
      spq_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occupied_i (CNT_W'(i) < count_q),
        .pass_i     (pass_w[i]),
        .new_i      (new_entry),
        .left_i     (left_e),
        .right_i    (right_e),
        .entry_o    (cell_entry[i]),
        .pass_o     (pass_w[i+1])
      );
    end
  end

  // Count and result for the item taken this cycle
  always_comb begin
    count_d  = count_q;
    res_d    = '0;
    status_d = spq_pkg::ST_OK;
    case (func)
      spq_pkg::FUNC_PUSH: begin
        if (full) begin
          status_d = spq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      spq_pkg::FUNC_TOP: begin
        if (empty) begin
          status_d = spq_pkg::ST_EMPTY;
        end else begin
          res_d = cell_entry[0];
        end
      end
      spq_pkg::FUNC_POP: begin
        if (empty) begin
          status_d = spq_pkg::ST_EMPTY;
        end else begin
          res_d   = cell_entry[0];
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        // unused code: no operation
      end
    endcase
    empty_d = (count_d == '0);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q    <= res_d;
      status_q <= status_d;
      empty_q  <= empty_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = res_q.value;
  assign out_priority_o = res_q.prio;
  assign status_o       = status_q;
  assign now_empty_o    = empty_q;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_priority_queue_unit
// Drives push, top and pop items with random gaps and output stalls. A
// scoreboard keeps its own sorted copy of the queue contents, predicts every
// result and compares it field by field. The run covers all four order
// modes, full and empty queues, and ties between equal priorities.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [1:0]  FUNC_NONE   = 2'd3;  // unused code, no operation
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

  // Expected result of one item
  typedef struct {
    logic signed [31:0] value;
    logic signed [31:0] prio;
    spq_pkg::status_e   status;
    logic               empty;
  } reply_t;

  // Scoreboard: sorted mirror of the queue and the replies still owed
  class pq_mirror;
    spq_pkg::entry_t held[$];
    spq_pkg::order_e mode;
    reply_t  pending_replies[$];
    int      errors;
    int      n_by_func[4];
    int      n_full;
    int      n_empty;

    function new();
      mode    = spq_pkg::ORDER_RESET;
      errors  = 0;
      n_full  = 0;
      n_empty = 0;
      foreach (n_by_func[k]) n_by_func[k] = 0;
    endfunction

    // A stored entry stays ahead of a new one while this holds
    function bit keeps_place(logic signed [31:0] stored, logic signed [31:0] fresh);
      case (mode)
        spq_pkg::ORD_LT: return stored < fresh;
        spq_pkg::ORD_LE: return stored <= fresh;
        spq_pkg::ORD_GT: return stored > fresh;
        default:         return stored >= fresh;
      endcase
    endfunction

    // Apply an accepted item to the mirror and queue its expected reply
    function void note_item(logic [1:0] func, logic signed [31:0] val,
                            logic signed [31:0] prio);
      reply_t          r;
      spq_pkg::entry_t e;
      int              pos;
      r.value  = '0;
      r.prio   = '0;
      r.status = spq_pkg::ST_OK;
      n_by_func[func]++;
      case (func)
        spq_pkg::FUNC_PUSH: begin
          if (held.size() >= spq_pkg::CAPACITY) begin
            r.status = spq_pkg::ST_FULL;
            n_full++;
          end else begin
            pos = 0;
            while (pos < held.size() && keeps_place(held[pos].prio, prio)) pos++;
            e.value = val;
            e.prio  = prio;
            held.insert(pos, e);
          end
        end
        spq_pkg::FUNC_TOP, spq_pkg::FUNC_POP: begin
          if (held.size() == 0) begin
            r.status = spq_pkg::ST_EMPTY;
            n_empty++;
          end else begin
            r.value = held[0].value;
            r.prio  = held[0].prio;
            if (func == spq_pkg::FUNC_POP) void'(held.pop_front());
          end
        end
        default: ;
      endcase
      r.empty = (held.size() == 0);
      pending_replies.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expected reply
    function void check_reply(logic signed [31:0] value, logic signed [31:0] prio,
                              logic [1:0] status, logic empty);
      reply_t x;
      if (pending_replies.size() == 0) begin
        $error("result with no item pending: value %0d priority %0d status %0d",
               value, prio, status);
        errors++;
        return;
      end
      x = pending_replies.pop_front();
      if (value !== x.value) begin
        $error("out_value: expected %0d, got %0d", x.value, value);
        errors++;
      end
      if (prio !== x.prio) begin
        $error("out_priority: expected %0d, got %0d", x.prio, prio);
        errors++;
      end
      if (status !== x.status) begin
        $error("status: expected %0d, got %0d", x.status, status);
        errors++;
      end
      if (empty !== x.empty) begin
        $error("now_empty: expected %0d, got %0d", x.empty, empty);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [1:0]         cfg_data_i     = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [1:0]         func_i         = '0;
  logic signed [31:0] elem_value_i   = '0;
  logic signed [31:0] priority_req_i = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic signed [31:0] out_value_o;
  logic signed [31:0] out_priority_o;
  logic [1:0]         status_o;
  logic               now_empty_o;

  pq_mirror mirror = new();
  int       cycle_count = 0;
  int       mode_writes = 0;
  bit       gaps_on     = 1'b1;
  bit       stalls_on   = 1'b1;

  sorted_priority_queue_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .elem_value_i   (elem_value_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_value_o    (out_value_o),
    .out_priority_o (out_priority_o),
    .status_o       (status_o),
    .now_empty_o    (now_empty_o)
  );

  always #4 clk_i = ~clk_i;

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      mirror.check_reply(out_value_o, out_priority_o, status_o, now_empty_o);
  end

  // Receiver: random stall before taking each result
  initial begin : receiver
    int n;
    wait (rst_ni);
    forever begin
      n = stalls_on ? $urandom_range(9, 0) : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, mirror.pending_replies.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input logic [1:0] func, input logic signed [31:0] val,
                           input logic signed [31:0] prio);
    int gap;
    gap = gaps_on ? $urandom_range(9, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= func;
    elem_value_i   <= val;
    priority_req_i <= prio;
    do @(posedge clk_i); while (in_stall_o);
    mirror.note_item(func, val, prio);
  endtask

  // Let every owed result drain
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (mirror.pending_replies.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_mode(input spq_pkg::order_e m);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    mirror.mode = m;
    mode_writes++;
  endtask

  // Priorities lean on a narrow band so ties are common
  function automatic logic signed [31:0] pick_prio();
    int r;
    r = $urandom_range(99, 0);
    if (r < 50) return $signed($urandom_range(6, 0)) - 3;
    if (r < 70) begin
      case ($urandom_range(3, 0))
        0:       return S32_MIN;
        1:       return S32_MAX;
        2:       return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(9, 0) == 0) return $urandom_range(1, 0) ? S32_MIN : S32_MAX;
    return $urandom;
  endfunction

  // Random traffic; the push share swings so the queue fills and drains
  task automatic run_phase(input int n_items);
    int push_pct;
    int r;
    push_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(2, 0))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
        gaps_on   = ($urandom_range(3, 0) != 0);
        stalls_on = ($urandom_range(3, 0) != 0);
      end
      r = $urandom_range(99, 0);
      if (r == 99)
        send_item(FUNC_NONE, $urandom, $urandom);
      else if (r < push_pct)
        send_item(spq_pkg::FUNC_PUSH, pick_value(), pick_prio());
      else if ($urandom_range(2, 0) == 0)
        send_item(spq_pkg::FUNC_TOP, $urandom, $urandom);
      else
        send_item(spq_pkg::FUNC_POP, $urandom, $urandom);
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue, extremes, ties under the reset mode
    send_item(spq_pkg::FUNC_POP, $urandom, $urandom);
    send_item(spq_pkg::FUNC_TOP, $urandom, $urandom);
    send_item(FUNC_NONE, $urandom, $urandom);
    send_item(spq_pkg::FUNC_PUSH, S32_MAX, 0);
    send_item(spq_pkg::FUNC_PUSH, S32_MIN, 0);
    send_item(spq_pkg::FUNC_PUSH, 1, S32_MAX);
    send_item(spq_pkg::FUNC_PUSH, -1, S32_MIN);
    send_item(spq_pkg::FUNC_PUSH, 5, 0);
    send_item(spq_pkg::FUNC_TOP, $urandom, $urandom);
    send_item(FUNC_NONE, $urandom, $urandom);
    repeat (5) send_item(spq_pkg::FUNC_POP, $urandom, $urandom);
    send_item(spq_pkg::FUNC_POP, $urandom, $urandom);

    // Directed: descending order with ties
    write_mode(spq_pkg::ORD_GE);
    send_item(spq_pkg::FUNC_PUSH, 10, S32_MIN);
    send_item(spq_pkg::FUNC_PUSH, 11, S32_MAX);
    send_item(spq_pkg::FUNC_PUSH, 12, S32_MAX);
    send_item(spq_pkg::FUNC_TOP, $urandom, $urandom);
    repeat (4) send_item(spq_pkg::FUNC_POP, $urandom, $urandom);

    // Random phases across every mode
    write_mode(spq_pkg::ORD_LT);
    run_phase(230);
    write_mode(spq_pkg::ORD_GT);
    run_phase(230);
    write_mode(spq_pkg::ORD_GE);
    run_phase(230);
    write_mode(spq_pkg::ORD_LE);
    run_phase(230);
    repeat (2) begin
      write_mode(spq_pkg::order_e'($urandom_range(3, 0)));
      run_phase(230);
    end

    wait_drained();
    $display("covered %0d pushes, %0d tops, %0d pops, %0d no-ops over %0d mode writes",
             mirror.n_by_func[spq_pkg::FUNC_PUSH], mirror.n_by_func[spq_pkg::FUNC_TOP],
             mirror.n_by_func[spq_pkg::FUNC_POP], mirror.n_by_func[FUNC_NONE],
             mode_writes);
    $display("dropped pushes on full queue: %0d, reads of empty queue: %0d, mismatches: %0d",
             mirror.n_full, mirror.n_empty, mirror.errors);
    if (mirror.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sorted_priority_queue_unit.f @@
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_unit.sv
tb/testbench.sv
